### rtl/cdq_pkg.sv
// Shared types, sizes and index helpers for the circular deque.
// Used by cdq_ptr and circular_deque; depends on nothing else.
package cdq_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int DATA_W   = 32;
  localparam int CAP_W    = 5;
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_REAR  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_NOP        = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Decision for one operation, handed from the pointer unit to the top level.
  typedef struct packed {
    status_t          status;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
  } cdq_dec_t;

  // An index at or beyond the last entry in use wraps to zero.
  function automatic logic [IDX_W-1:0] idx_advance(input logic [IDX_W-1:0] i,
                                                   input logic [IDX_W-1:0] last);
    return (i >= last) ? '0 : i + IDX_W'(1);
  endfunction

  // Index zero steps back to the last entry in use.
  function automatic logic [IDX_W-1:0] idx_retreat(input logic [IDX_W-1:0] i,
                                                   input logic [IDX_W-1:0] last);
    return (i == '0) ? last : i - IDX_W'(1);
  endfunction

endpackage

### rtl/cdq_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; no package needed.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/cdq_ptr.sv
// Pointer unit: capacity register, head and tail indexes, empty flag,
// and the per-operation decision. Depends on cdq_pkg.
module cdq_ptr (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]  cfg_data,
  input  logic                       fire,
  input  logic [cdq_pkg::ACT_W-1:0]  action,
  output cdq_pkg::cdq_dec_t          dec
);
  import cdq_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic             empty, empty_next;
  logic [IDX_W-1:0] last;
  logic             full;
  action_t          act;

  // Clamp the capacity register to 1..DEPTH and keep the last usable index.
  always_comb begin
    if (capacity == '0) begin
      last = '0;
    end else if (32'(capacity) > 32'(DEPTH)) begin
      last = IDX_W'(DEPTH - 1);
    end else begin
      last = IDX_W'(capacity - CAP_W'(1));
    end
  end

  assign act  = action_t'(action);
  assign full = !empty && (idx_advance(tail, last) == head);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    dec.status = ST_DONE;
    dec.wr_en  = 1'b0;
    dec.rd_en  = 1'b0;
    dec.addr   = head;
    case (act)
      ACT_PUSH_REAR, ACT_PUSH_FRONT: begin
        if (full) begin
          dec.status = ST_FULL;
        end else if (empty) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          dec.wr_en  = fire;
          dec.addr   = '0;
        end else if (act == ACT_PUSH_REAR) begin
          tail_next = idx_advance(tail, last);
          dec.wr_en = fire;
          dec.addr  = tail_next;
        end else begin
          head_next = idx_retreat(head, last);
          dec.wr_en = fire;
          dec.addr  = head_next;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          dec.status = ST_EMPTY;
        end else begin
          dec.rd_en = fire;
          dec.addr  = head;
          if (head == tail) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end else begin
            head_next = idx_advance(head, last);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
    end else if (fire) begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

endmodule

### rtl/circular_deque.sv
// Top level of the circular deque: sequencer, result register and the
// ring memory. Depends on cdq_pkg, cdq_ptr and cdq_ram.
//
// Usage: each beat on the item channel carries an action (push at the
// rear, push at the front, pop at the front, or the unused code, which
// does nothing) and a 32-bit value. Every item produces exactly one
// beat on the result channel with a status and, for a successful pop,
// the word taken from the front; popped_value is zero otherwise.
// A push to a full queue or a pop from an empty queue is refused with
// the matching status and changes nothing.
// Flow: pushes, refusals and the no-op are answered from the result
// register, loaded when the item is accepted, so they run at one item
// per cycle while the result channel does not stall. A successful pop
// reads the ring memory through its registered read port and loads the
// result register in S_READ; the item channel stalls in S_READ.
// The capacity register is written through cfg_we and cfg_data; the user
// must do so only while idle (not enforced); it resets to 16 entries.
// Reset clears the queue to empty and drops any pending result; the
// memory contents are not cleared. When the receiver stalls, the result
// beat holds and the item channel stalls until the result is taken.
module circular_deque (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]      cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [cdq_pkg::ACT_W-1:0]      action,
  input  logic signed [cdq_pkg::DATA_W-1:0] value,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [cdq_pkg::STATUS_W-1:0]   status,
  output logic signed [cdq_pkg::DATA_W-1:0] popped_value
);
  import cdq_pkg::*;

  state_t             state, state_next;
  cdq_dec_t           dec;
  logic               fire;
  logic               out_free;
  logic               load_direct;
  logic               load_read;
  logic [DATA_W-1:0]  rdata;

  // The result register is free when it is empty or its beat leaves now.
  assign out_free = !result_valid || !result_stall;
  assign fire     = item_valid && !item_stall;

  cdq_ptr u_ptr (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (fire),
    .action   (action),
    .dec      (dec)
  );

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (dec.wr_en),
    .re    (dec.rd_en),
    .addr  (dec.addr),
    .wdata (value),
    .rdata (rdata)
  );

  // Next state: a successful pop waits in S_READ for the memory read.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (fire && dec.rd_en) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer. In the read cycle the result register is
  // known to be empty, since the pop was only taken when it was free.
  always_comb begin
    item_stall  = 1'b1;
    load_direct = 1'b0;
    load_read   = 1'b0;
    case (state)
      S_IDLE: begin
        item_stall  = !out_free;
        load_direct = item_valid && out_free && !dec.rd_en;
      end
      S_READ: begin
        load_read = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_direct || load_read) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      status       <= dec.status;
      popped_value <= '0;
    end else if (load_read) begin
      status       <= ST_DONE;
      popped_value <= rdata;
    end
  end

endmodule
